FILE: hdl/fmprf_pkg.sv
// Package with the shared types and constants of the packet rule filter.
package fmprf_pkg;

  localparam int RuleSlotsDefault = 128;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADNUM = 2'd2;

  localparam logic [8:0] PROTO_ANY = 9'd256;

  localparam int RuleW = 64 + 64 + 48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat
    logic ins_write;  // write the new rule at the table end
    logic rd_start;   // issue a read at the walk index
    logic mv_write;   // write the rule read previously one slot down
    logic hit_write;  // write back the incremented hit count
    logic idx_inc;    // advance the walk index
    logic idx_load;   // load the walk index with the rule number
    logic cnt_inc;
    logic cnt_dec;
    logic set_match;
    logic set_full;
    logic set_bad;
  } fmprf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       bad_num;
    logic       walk_end;   // walk index has reached the rule count
    logic       rule_hit;   // registered read data matches the packet
  } fmprf_sts_t;

endpackage

FILE: hdl/fmprf_datapath.sv
// Datapath of the rule filter: rule memories, walk index, matcher and result register.
module fmprf_datapath #(
  parameter int RULE_SLOTS = fmprf_pkg::RuleSlotsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fmprf_pkg::fmprf_cmd_t  cmd,
  output fmprf_pkg::fmprf_sts_t  sts,
  input  logic [185:0]           in_beat,
  output logic [51:0]            res
);
  import fmprf_pkg::*;

  localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CW = $clog2(RULE_SLOTS + 1);

  // Rule and hit memories, one write and one registered read port each.
  logic [RuleW-1:0] rules_mem [RULE_SLOTS];
  logic [31:0]      hits_mem  [RULE_SLOTS];

  logic [185:0]     beat_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [RuleW-1:0] rd_rule_r;
  logic [31:0]      rd_hits_r;
  logic [43:0]      res_r, res_nxt;

  logic [1:0]  op;
  logic        dir, act;
  logic [4:0]  flg;
  logic [31:0] sa, sm, da, dm;
  logic [8:0]  pr;
  logic [15:0] sp, dp;
  logic [7:0]  num;

  assign op  = beat_r[1:0];
  assign dir = beat_r[2];
  assign act = beat_r[3];
  assign flg = beat_r[8:4];
  assign sa  = beat_r[40:9];
  assign sm  = beat_r[72:41];
  assign da  = beat_r[104:73];
  assign dm  = beat_r[136:105];
  assign pr  = beat_r[145:137];
  assign sp  = beat_r[161:146];
  assign dp  = beat_r[177:162];
  assign num = beat_r[185:178];

  logic [CW-1:0] num_w;
  assign num_w = CW'(num);

  // Stored rule fields: source, destination, attributes.
  logic [31:0] r_sa, r_sm, r_da, r_dm;
  logic [47:0] r_at;
  assign r_sa = rd_rule_r[175:144];
  assign r_sm = rd_rule_r[143:112];
  assign r_da = rd_rule_r[111:80];
  assign r_dm = rd_rule_r[79:48];
  assign r_at = rd_rule_r[47:0];

  logic src_ok, dst_ok, pr_ok, sp_ok, dp_ok;
  assign src_ok = !r_at[2] || sa == r_sa || r_sm == '0 || (sa & r_sm) == (r_sa & r_sm);
  assign dst_ok = !r_at[3] || da == r_da || r_dm == '0 || (da & r_dm) == (r_da & r_dm);
  assign pr_ok  = !r_at[4] || r_at[15:7] == PROTO_ANY || r_at[15:7] == pr;
  assign sp_ok  = !r_at[5] || r_at[31:16] == sp;
  assign dp_ok  = !r_at[6] || r_at[47:32] == dp;

  assign sts.op       = op;
  assign sts.full     = cnt_r >= CW'(RULE_SLOTS);
  assign sts.bad_num  = num == '0 || 32'(num) > 32'(cnt_r);
  assign sts.walk_end = idx_r >= cnt_r;
  assign sts.rule_hit = (r_at[0] == dir) && src_ok && dst_ok && pr_ok && sp_ok && dp_ok;

  logic [AW-1:0] idx_a, prev_a, mv_a, cnt_a;
  assign idx_a  = idx_r[AW-1:0];
  assign prev_a = AW'(idx_r - 1'b1);
  // The walk index has already moved past the slot that was read.
  assign mv_a   = AW'(idx_r - CW'(2));
  assign cnt_a  = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) beat_r <= in_beat;
    if (cmd.ins_write) begin
      rules_mem[cnt_a] <= {sa, sm, da, dm, dp, sp, pr, flg, act, dir};
      hits_mem[cnt_a]  <= '0;
    end else if (cmd.mv_write) begin
      rules_mem[mv_a] <= rd_rule_r;
      hits_mem[mv_a]  <= rd_hits_r;
    end else if (cmd.hit_write) begin
      hits_mem[prev_a] <= rd_hits_r + 32'd1;
    end
    if (cmd.rd_start) begin
      rd_rule_r <= rules_mem[idx_a];
      rd_hits_r <= hits_mem[idx_a];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) cnt_nxt = cnt_r + 1'b1;
    if (cmd.cnt_dec) cnt_nxt = cnt_r - 1'b1;
    idx_nxt = idx_r;
    if (cmd.load) idx_nxt = '0;
    else if (cmd.idx_load) idx_nxt = num_w;
    else if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
    res_nxt = res_r;
    // res: verdict, matched, matched_rule, hit_count, status; rule_count is added later
    if (cmd.load) res_nxt = '0;
    if (cmd.set_match) begin
      res_nxt[0]     = r_at[1];
      res_nxt[1]     = 1'b1;
      res_nxt[9:2]   = 8'(idx_r);
      res_nxt[41:10] = rd_hits_r + 32'd1;
    end
    if (cmd.set_full) res_nxt[43:42] = ST_FULL;
    if (cmd.set_bad)  res_nxt[43:42] = ST_BADNUM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign res = {8'(cnt_r), res_r};
endmodule

FILE: hdl/fmprf_ctrl.sv
// Controller state machine of the rule filter.
module fmprf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  output logic                   busy,
  output logic                   done,
  input  logic                   out_free,
  input  fmprf_pkg::fmprf_sts_t  sts,
  output fmprf_pkg::fmprf_cmd_t  cmd
);
  import fmprf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_MOVE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_INSERT: begin
            if (sts.full) cmd.set_full = 1'b1;
            else begin
              cmd.ins_write = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
            state_nxt = S_DONE;
          end
          OP_DELETE: begin
            if (sts.bad_num) begin
              cmd.set_bad = 1'b1;
              state_nxt = S_DONE;
            end else begin
              // The walk starts on the slot after the removed rule.
              cmd.idx_load = 1'b1;
              state_nxt = S_MOVE;
            end
          end
          OP_CLASSIFY: state_nxt = S_READ;
          default: state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        if (sts.walk_end) state_nxt = S_DONE;
        else begin
          cmd.rd_start = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == OP_CLASSIFY) begin
          if (sts.rule_hit) begin
            cmd.set_match = 1'b1;
            cmd.hit_write = 1'b1;
            state_nxt = S_DONE;
          end else state_nxt = S_READ;
        end else begin
          cmd.mv_write = 1'b1;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        if (sts.walk_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_start = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

FILE: hdl/first_match_packet_rule_filter.sv
// Top level of the first-match packet rule filter.
// Input channel in_*: one beat is one operation (insert, delete or classify).
// Output channel out_*: exactly one result beat for each input beat, in order.
// An insert, an unused op or a rejected delete goes straight from decode to
// its result. Classify reads the stored rules one at a time through the
// registered rule memory read and the matcher and stops at the first rule
// that matches, or after the last stored rule. A delete moves every later
// rule down one slot, with one read and one write per moved rule.
// One operation is in flight at a time; in_tready is high while the
// controller is idle, also while a result still waits in the output register.
// A finished result is written to that register only once it is free.
// While out_tready is low the result holds and the controller waits.
// Reset (rst_n low, synchronous) empties the rule table and drops any result.
module first_match_packet_rule_filter #(
  parameter int RULE_SLOTS = fmprf_pkg::RuleSlotsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op, direction, rule_action, match_flags, src_addr, src_mask, dst_addr,
  // dst_mask, protocol, src_port, dst_port, rule_number; zero filled
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // verdict, matched, matched_rule, hit_count, status, rule_count; zero filled
  output logic [55:0]  out_tdata
);
  import fmprf_pkg::*;

  fmprf_cmd_t cmd;
  fmprf_sts_t sts;
  logic busy, done, out_free;
  logic [51:0] res;
  logic [51:0] out_r;
  logic        out_v_r;

  assign in_tready = !busy;
  assign out_free  = !out_v_r || out_tready;

  fmprf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .busy(busy),
    .done(done), .out_free(out_free), .sts(sts), .cmd(cmd)
  );

  fmprf_datapath #(.RULE_SLOTS(RULE_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_beat(in_tdata[185:0]), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (done) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
    if (done) out_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r};
endmodule
